/* hdl/bsc_pkg.sv */
// shared types and constants for the barometric compensation block
`default_nettype none
package bsc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RawW = 19;
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SENS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TSCALE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TOFF = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUAD = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CURVE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OSS = 3'd6;
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_PRES = 1'b1;

  typedef struct packed {
    logic start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage
`default_nettype wire

/* hdl/bsc_if.sv */
// valid/ready channel interfaces
`default_nettype none
interface bsc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [18:0] raw_reading;
  modport source(output valid, cmd, raw_reading, input ready);
  modport sink(input valid, cmd, raw_reading, output ready);
endinterface

interface bsc_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic signed [31:0] value;
  logic divide_error;
  modport source(output valid, kind, value, divide_error, input ready);
  modport sink(input valid, kind, value, divide_error, output ready);
endinterface

interface bsc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/bsc_div.sv */
// unsigned 32-bit restoring divider, one quotient bit per cycle
`default_nettype none
module bsc_div (
  input wire logic clk,
  input wire logic rst,
  input wire bsc_pkg::div_req_t req,
  output bsc_pkg::div_rsp_t rsp
);
  import bsc_pkg::*;
  logic [31:0] rem, quo, den;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [33:0] trial;
  assign trial = {1'b0, rem, quo[31]} - {2'b00, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= req.num;
        den <= req.den;
        cnt <= 6'd32;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end
  assign rsp = '{done: done, quo: quo};
endmodule
`default_nettype wire

/* hdl/barometric_sensor_compensation.sv */
// top level: sequencer with one shared multiplier and a serial divider
// Usage notes:
//   in  channel: cmd (0 temperature, 1 pressure) and raw_reading, one beat per item.
//   out channel: kind, value and divide_error, one beat per input item.
//   cfg channel: index and data; always ready, write only while idle.
// Each item runs through a sequencer that issues one 32x32 multiply per step
// and one 32-bit division on a bit-serial divider.
// Most of the time from the input beat to the output beat is spent in the
// divider; a zero divisor ends the item early, before the divider starts.
// One item is in flight at a time; the next input beat can come in the
// cycle after the output beat.
// The result waits in an output register; in.ready stays low until that
// result beat is taken, so a stalled receiver stalls the input.
// Reset clears all coefficients, the stored temperature term and the
// sequencer; no result is pending afterward.
`default_nettype none
module barometric_sensor_compensation (
  input wire logic clk,
  input wire logic rst,
  bsc_in_if.sink in,
  bsc_out_if.source out,
  bsc_cfg_if.sink cfg
);
  import bsc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_TDIV, S_TFIN,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_PDIV,
    S_Q1, S_Q2, S_Q3, S_Q4, S_DONE
  } state_t;

  state_t state;
  logic [47:0] offset_coeffs;
  logic [15:0] sensitivity_coeff, temp_scale_coeff, temp_offset_coeff;
  logic [31:0] quadratic_coeffs, temp_curve_coeffs;
  logic [1:0] oversampling;
  logic [31:0] temperature_term;
  logic cmd;
  logic [18:0] raw;
  logic [31:0] b6, sq, ra, rb, rc, p, acc;
  logic neg;
  logic [31:0] ma, mb, prod;
  div_req_t dreq;
  div_rsp_t drsp;

  assign prod = ma * mb;
  bsc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg.ready = 1'b1;
  assign in.ready = (state == S_IDLE) && !out.valid;

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  logic [31:0] ac1, ac2, ac3, b1, b2, mc, md, b3raw, b4, b7;
  assign ac1 = sx16(offset_coeffs[47:32]);
  assign ac2 = sx16(offset_coeffs[31:16]);
  assign ac3 = sx16(offset_coeffs[15:0]);
  assign b1 = sx16(quadratic_coeffs[31:16]);
  assign b2 = sx16(quadratic_coeffs[15:0]);
  assign mc = sx16(temp_curve_coeffs[31:16]);
  assign md = sx16(temp_curve_coeffs[15:0]);

  always_comb begin
    ma = b6;
    mb = b6;
    case (state)
      S_T1: begin ma = {13'd0, raw} - {16'd0, temp_offset_coeff}; mb = {16'd0, temp_scale_coeff}; end
      S_P1: begin ma = b6; mb = b6; end
      S_P2: begin ma = b2; mb = sq; end
      S_P3: begin ma = ac2; mb = b6; end
      S_P4: begin ma = ac3; mb = b6; end
      S_P5: begin ma = b1; mb = sq; end
      S_P6: begin ma = {16'd0, sensitivity_coeff}; mb = ra + 32'd32768; end
      S_P7: begin ma = {13'd0, raw} - rc; mb = 32'd50000 >> oversampling; end
      S_Q1: begin ma = asr(p, 8); mb = asr(p, 8); end
      S_Q2: begin ma = ra; mb = 32'd3038; end
      S_Q3: begin ma = 32'd0 - 32'd7357; mb = p; end
      default: begin ma = b6; mb = b6; end
    endcase
  end

  // b3 = sdiv(x, 4): truncate toward zero
  logic [31:0] b3x;
  assign b3x = ((ac1 * 32'd4 + acc) << oversampling) + 32'd2;
  assign b3raw = b3x[31] ? 32'd0 - ((32'd0 - b3x) >> 2) : (b3x >> 2);
  assign b4 = rb;
  assign b7 = ra;

  // temperature divisor
  logic [31:0] tden;
  assign tden = ra + md;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
      offset_coeffs <= '0;
      sensitivity_coeff <= '0;
      temp_scale_coeff <= '0;
      temp_offset_coeff <= '0;
      quadratic_coeffs <= '0;
      temp_curve_coeffs <= '0;
      oversampling <= '0;
      temperature_term <= '0;
      dreq <= '0;
    end else begin
      dreq.start <= ((state == S_T2) && (tden != 32'd0)) ||
                    ((state == S_P8) && (b4 != 32'd0));
      if (cfg.valid) begin
        case (cfg.index)
          REG_OFFSET: offset_coeffs <= cfg.data;
          REG_SENS: sensitivity_coeff <= cfg.data[15:0];
          REG_TSCALE: temp_scale_coeff <= cfg.data[15:0];
          REG_TOFF: temp_offset_coeff <= cfg.data[15:0];
          REG_QUAD: quadratic_coeffs <= cfg.data[31:0];
          REG_CURVE: temp_curve_coeffs <= cfg.data[31:0];
          REG_OSS: oversampling <= cfg.data[1:0];
          default: ;
        endcase
      end
      if (out.valid && out.ready) out.valid <= 1'b0;
      case (state)
        S_IDLE: if (in.valid && in.ready) begin
          cmd <= in.cmd;
          raw <= in.raw_reading;
          b6 <= temperature_term - 32'd4000;
          state <= (in.cmd == CMD_TEMP) ? S_T1 : S_P1;
        end
        S_T1: begin ra <= asr(prod, 15); state <= S_T2; end
        S_T2: begin
          rb <= tden;
          if (tden == 32'd0) begin
            out.kind <= cmd; out.value <= '0; out.divide_error <= 1'b1;
            state <= S_DONE;
          end else begin
            dreq.num <= mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
            dreq.den <= tden[31] ? 32'd0 - tden : tden;
            neg <= mc[31] ^ tden[31];
            state <= S_TDIV;
          end
        end
        S_TDIV: if (drsp.done) begin
          rc <= ra + (neg ? 32'd0 - drsp.quo : drsp.quo);
          state <= S_TFIN;
        end
        S_TFIN: begin
          temperature_term <= rc;
          out.kind <= cmd; out.value <= asr(rc + 32'd8, 4); out.divide_error <= 1'b0;
          state <= S_DONE;
        end
        S_P1: begin sq <= asr(prod, 12); state <= S_P2; end
        S_P2: begin acc <= asr(prod, 11); state <= S_P3; end
        S_P3: begin acc <= acc + asr(prod, 11); state <= S_P4; end
        S_P4: begin rc <= b3raw; ra <= asr(prod, 13); state <= S_P5; end
        S_P5: begin ra <= asr(ra + asr(prod, 16) + 32'd2, 2); state <= S_P6; end
        S_P6: begin rb <= prod >> 15; state <= S_P7; end
        S_P7: begin ra <= prod; state <= S_P8; end
        S_P8: begin
          if (b4 == 32'd0) begin
            out.kind <= cmd; out.value <= '0; out.divide_error <= 1'b1;
            state <= S_DONE;
          end else begin
            dreq.num <= b7[31] ? b7 : (b7 << 1);
            dreq.den <= b4;
            neg <= b7[31];
            state <= S_PDIV;
          end
        end
        S_PDIV: if (drsp.done) begin
          p <= neg ? (drsp.quo << 1) : drsp.quo;
          state <= S_Q1;
        end
        S_Q1: begin ra <= prod; state <= S_Q2; end
        S_Q2: begin ra <= asr(prod, 16); state <= S_Q3; end
        S_Q3: begin
          out.kind <= cmd;
          out.value <= p + asr(ra + asr(prod, 16) + 32'd3791, 4);
          out.divide_error <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin out.valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in.ready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> out.valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.divide_error) |-> (out.value == 32'sd0))
    else $error("error result not zero");
endmodule
`default_nettype wire
